// ----- rtl/core/lnpc_pkg.sv -----
// ----------------------------------------------------------------------------
// lnpc_pkg
// Shared constants for the line pick test: coordinate and tolerance widths,
// tolerance reset value, clip limit and outcode bit positions.
// ----------------------------------------------------------------------------
package lnpc_pkg;

  localparam int unsigned COORD_WIDTH_DEF = 16;
  localparam int unsigned FRAC_BITS       = 4;
  localparam int unsigned TOL_WIDTH       = 11;
  localparam int unsigned TOL_RESET_INT   = 6;

  // 6.0 in the coordinate fixed-point format
  localparam logic [TOL_WIDTH-1:0] TOL_RESET = TOL_WIDTH'(TOL_RESET_INT * (2 ** FRAC_BITS));

  localparam int unsigned MAX_CLIPS = 4;
  localparam int unsigned STEP_W    = $clog2(MAX_CLIPS + 1);

  // outcode bit positions
  localparam int unsigned OC_LEFT  = 0;
  localparam int unsigned OC_RIGHT = 1;
  localparam int unsigned OC_BELOW = 2;
  localparam int unsigned OC_ABOVE = 3;
  localparam int unsigned OC_W     = 4;

endpackage

// ----- rtl/core/line_near_point_clip_test_top.sv -----
// ----------------------------------------------------------------------------
// line_near_point_clip_test_top
// Sequence: k clip steps (0..4), each a test, one multiply, a restoring divide and an
//   update (test and update only for a zero denominator), then a final test
// Throughput: one segment at a time; a new beat is taken once the result is
//   registered, also while that result still waits downstream
// Reset: asynchronous, active low; clears sequencer and output valid, tolerance 6.0
// ----------------------------------------------------------------------------
module line_near_point_clip_test_top #(
  parameter int unsigned COORD_WIDTH = lnpc_pkg::COORD_WIDTH_DEF
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  // tolerance register write
  input  logic                                        cfg_valid_i,
  output logic                                        cfg_ready_o,
  input  logic [lnpc_pkg::TOL_WIDTH-1:0]              cfg_data_i,
  // segment and probe
  input  logic                                        s_axis_tvalid,
  output logic                                        s_axis_tready,
  // start_x, start_y, end_x, end_y, probe_x, probe_y, zero pad
  input  logic [((6*COORD_WIDTH+7)/8)*8-1:0]          s_axis_tdata,
  // result
  output logic                                        m_axis_tvalid,
  input  logic                                        m_axis_tready,
  // hit, zero pad
  output logic [7:0]                                  m_axis_tdata
);

  import lnpc_pkg::*;

  localparam int unsigned W   = COORD_WIDTH;
  // window edges hold probe +/- tolerance exactly
  localparam int unsigned EW  = ((W > TOL_WIDTH) ? W : TOL_WIDTH + 1) + 1;
  localparam int unsigned DW  = W + 1;          // coordinate difference
  localparam int unsigned NW  = EW + 1;         // edge minus coordinate
  localparam int unsigned MW  = DW + NW - 1;    // product magnitude, quotient
  localparam int unsigned SW  = MW + 2;         // interpolation sum
  localparam int unsigned CNT_W = $clog2(MW);

  localparam logic signed [SW-1:0] SAT_HI = {{(SW-W+1){1'b0}}, {(W-1){1'b1}}};
  localparam logic signed [SW-1:0] SAT_LO = {{(SW-W+1){1'b1}}, {(W-1){1'b0}}};

  typedef enum logic [2:0] {
    S_IDLE,
    S_TEST,
    S_MUL,
    S_DIV,
    S_UPD
  } state_e;

  function automatic logic signed [W-1:0] sat_coord(input logic signed [SW-1:0] v);
    logic signed [W-1:0] r;
    if (v > SAT_HI) begin
      r = SAT_HI[W-1:0];
    end else if (v < SAT_LO) begin
      r = SAT_LO[W-1:0];
    end else begin
      r = v[W-1:0];
    end
    return r;
  endfunction

  // control registers
  state_e              state_q, state_d;
  logic [STEP_W-1:0]   step_q, step_d;
  logic                out_valid_q, out_valid_d;
  logic                hit_q, hit_d;
  logic [TOL_WIDTH-1:0] tol_q;

  // datapath registers
  logic signed [W-1:0]  x0_q, x0_d, y0_q, y0_d, x1_q, x1_d, y1_q, y1_d;
  logic signed [EW-1:0] xmin_q, xmin_d, xmax_q, xmax_d, ymin_q, ymin_d, ymax_q, ymax_d;
  logic                 first_q, first_d;
  logic                 horiz_q, horiz_d;
  logic                 neg_q, neg_d;
  logic                 zden_q, zden_d;
  logic signed [EW-1:0] edge_q, edge_d;
  logic [DW-1:0]        mag_a_q, mag_a_d;
  logic [NW-1:0]        mag_b_q, mag_b_d;
  logic [DW-1:0]        dvs_q, dvs_d;
  logic [DW-1:0]        rem_q, rem_d;
  logic [MW-1:0]        dvd_q, dvd_d;
  logic [CNT_W-1:0]     cnt_q, cnt_d;

  // combinational helpers
  logic signed [W-1:0]  in_x0, in_y0, in_x1, in_y1, in_px, in_py;
  logic signed [EW-1:0] in_pxe, in_pye, tol_e;
  logic [OC_W-1:0]      c0, c1, co;
  logic signed [EW-1:0] x0e, y0e, x1e, y1e;
  logic                 clip_horiz;
  logic signed [EW-1:0] clip_edge;
  logic signed [W-1:0]  a0, a1, b0, b1;
  logic signed [DW-1:0] a_diff, den;
  logic signed [NW-1:0] b_num;
  logic [DW:0]          trial;
  logic                 trial_ge;
  logic signed [W-1:0]  ua0;
  logic signed [SW-1:0] q_s, sum_s;
  logic signed [W-1:0]  interp_v, edge_v;

  assign in_x0 = s_axis_tdata[0*W +: W];
  assign in_y0 = s_axis_tdata[1*W +: W];
  assign in_x1 = s_axis_tdata[2*W +: W];
  assign in_y1 = s_axis_tdata[3*W +: W];
  assign in_px = s_axis_tdata[4*W +: W];
  assign in_py = s_axis_tdata[5*W +: W];

  assign in_pxe = {{(EW-W){in_px[W-1]}}, in_px};
  assign in_pye = {{(EW-W){in_py[W-1]}}, in_py};
  assign tol_e  = {{(EW-TOL_WIDTH){1'b0}}, tol_q};

  assign x0e = {{(EW-W){x0_q[W-1]}}, x0_q};
  assign y0e = {{(EW-W){y0_q[W-1]}}, y0_q};
  assign x1e = {{(EW-W){x1_q[W-1]}}, x1_q};
  assign y1e = {{(EW-W){y1_q[W-1]}}, y1_q};

  // outcodes with strict compares, right before left and above before below
  always_comb begin
    c0 = '0;
    c1 = '0;
    c0[OC_RIGHT] = x0e > xmax_q;
    c0[OC_LEFT]  = !(x0e > xmax_q) && (x0e < xmin_q);
    c0[OC_ABOVE] = y0e > ymax_q;
    c0[OC_BELOW] = !(y0e > ymax_q) && (y0e < ymin_q);
    c1[OC_RIGHT] = x1e > xmax_q;
    c1[OC_LEFT]  = !(x1e > xmax_q) && (x1e < xmin_q);
    c1[OC_ABOVE] = y1e > ymax_q;
    c1[OC_BELOW] = !(y1e > ymax_q) && (y1e < ymin_q);
  end

  // clip edge choice: top, bottom, right, left
  always_comb begin
    co         = (|c0) ? c0 : c1;
    clip_horiz = co[OC_ABOVE] || co[OC_BELOW];
    if (co[OC_ABOVE]) begin
      clip_edge = ymax_q;
    end else if (co[OC_BELOW]) begin
      clip_edge = ymin_q;
    end else if (co[OC_RIGHT]) begin
      clip_edge = xmax_q;
    end else begin
      clip_edge = xmin_q;
    end
    a0 = clip_horiz ? x0_q : y0_q;
    a1 = clip_horiz ? x1_q : y1_q;
    b0 = clip_horiz ? y0_q : x0_q;
    b1 = clip_horiz ? y1_q : x1_q;
    a_diff = {a1[W-1], a1} - {a0[W-1], a0};
    den    = {b1[W-1], b1} - {b0[W-1], b0};
    b_num  = {clip_edge[EW-1], clip_edge} - {{(NW-W){b0[W-1]}}, b0};
  end

  // one restoring divide step
  assign trial    = {rem_q, dvd_q[MW-1]};
  assign trial_ge = trial >= {1'b0, dvs_q};

  // endpoint update after the divide; a zero denominator keeps the old coordinate
  always_comb begin
    ua0      = horiz_q ? x0_q : y0_q;
    q_s      = neg_q ? -{2'b00, dvd_q} : {2'b00, dvd_q};
    sum_s    = {{(SW-W){ua0[W-1]}}, ua0} + q_s;
    interp_v = zden_q ? ua0 : sat_coord(sum_s);
    edge_v   = sat_coord({{(SW-EW){edge_q[EW-1]}}, edge_q});
  end

  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q;
    hit_d       = hit_q;
    x0_d = x0_q;  y0_d = y0_q;  x1_d = x1_q;  y1_d = y1_q;
    xmin_d = xmin_q;  xmax_d = xmax_q;  ymin_d = ymin_q;  ymax_d = ymax_q;
    first_d = first_q;
    horiz_d = horiz_q;
    neg_d   = neg_q;
    zden_d  = zden_q;
    edge_d  = edge_q;
    mag_a_d = mag_a_q;
    mag_b_d = mag_b_q;
    dvs_d   = dvs_q;
    rem_d   = rem_q;
    dvd_d   = dvd_q;
    cnt_d   = cnt_q;

    if (m_axis_tvalid && m_axis_tready) begin
      out_valid_d = 1'b0;
    end

    case (state_q)
      S_IDLE: begin
        if (s_axis_tvalid) begin
          x0_d = in_x0;  y0_d = in_y0;  x1_d = in_x1;  y1_d = in_y1;
          xmin_d = in_pxe - tol_e;
          xmax_d = in_pxe + tol_e;
          ymin_d = in_pye - tol_e;
          ymax_d = in_pye + tol_e;
          step_d  = '0;
          state_d = S_TEST;
        end
      end
      S_TEST: begin
        if (((c0 == '0) && (c1 == '0)) || ((c0 & c1) != '0) ||
            (step_q == STEP_W'(MAX_CLIPS))) begin
          // hold the decision until the output register is free
          if (!out_valid_q || m_axis_tready) begin
            out_valid_d = 1'b1;
            hit_d       = (c0 == '0) && (c1 == '0);
            state_d     = S_IDLE;
          end
        end else begin
          first_d = |c0;
          horiz_d = clip_horiz;
          edge_d  = clip_edge;
          mag_a_d = a_diff[DW-1] ? DW'(-a_diff) : DW'(a_diff);
          mag_b_d = b_num[NW-1] ? NW'(-b_num) : NW'(b_num);
          dvs_d   = den[DW-1] ? DW'(-den) : DW'(den);
          neg_d   = a_diff[DW-1] ^ b_num[NW-1] ^ den[DW-1];
          zden_d  = den == '0;
          state_d = (den == '0) ? S_UPD : S_MUL;
        end
      end
      S_MUL: begin
        dvd_d   = MW'(mag_a_q * mag_b_q);
        rem_d   = '0;
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        rem_d = trial_ge ? DW'(trial - {1'b0, dvs_q}) : trial[DW-1:0];
        dvd_d = {dvd_q[MW-2:0], trial_ge};
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CNT_W'(MW - 1)) begin
          state_d = S_UPD;
        end
      end
      S_UPD: begin
        if (first_q) begin
          x0_d = horiz_q ? interp_v : edge_v;
          y0_d = horiz_q ? edge_v : interp_v;
        end else begin
          x1_d = horiz_q ? interp_v : edge_v;
          y1_d = horiz_q ? edge_v : interp_v;
        end
        step_d  = step_q + 1'b1;
        state_d = S_TEST;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
      hit_q       <= 1'b0;
      tol_q       <= TOL_RESET;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
      hit_q       <= hit_d;
      if (cfg_valid_i) begin
        tol_q <= cfg_data_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    x0_q    <= x0_d;
    y0_q    <= y0_d;
    x1_q    <= x1_d;
    y1_q    <= y1_d;
    xmin_q  <= xmin_d;
    xmax_q  <= xmax_d;
    ymin_q  <= ymin_d;
    ymax_q  <= ymax_d;
    first_q <= first_d;
    horiz_q <= horiz_d;
    neg_q   <= neg_d;
    zden_q  <= zden_d;
    edge_q  <= edge_d;
    mag_a_q <= mag_a_d;
    mag_b_q <= mag_b_d;
    dvs_q   <= dvs_d;
    rem_q   <= rem_d;
    dvd_q   <= dvd_d;
    cnt_q   <= cnt_d;
  end

  assign cfg_ready_o   = 1'b1;
  assign s_axis_tready = state_q == S_IDLE;
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {7'b0000000, hit_q};

endmodule
